// ===== src/mueller_muller_timing_recovery_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Mueller-Muller timing recovery assertion macros
// Shorthand for the concurrent checks used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef MUELLER_MULLER_TIMING_RECOVERY_UNIT_MACROS_SVH
`define MUELLER_MULLER_TIMING_RECOVERY_UNIT_MACROS_SVH

// Check that is switched off while reset is high.
`define MMTR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mmtr check failed");

// Check that also holds while reset is high.
`define MMTR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mmtr check failed");

`endif

// ===== src/mmtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mueller-Muller timing recovery package
// Widths, register map, reset values and shared types of the block.
// ----------------------------------------------------------------------------
package mmtr_pkg;

   localparam int FRAC_BITS = 24;
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 32;
   localparam int SKIP_W    = 8;

   // Products of a sample and a gain, and the sums built from them.
   localparam int PROD_W  = SAMPLE_W + GAIN_W;
   localparam int TERM_W  = PROD_W + 1;
   localparam int ERR_W   = TERM_W + 1;
   localparam int STEP_W  = ERR_W + 1;
   localparam int PHASE_W = STEP_W + 1;
   localparam int INT_W   = PHASE_W - FRAC_BITS;

   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_STEP_GAIN    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PHASE_GAIN   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_NOMINAL_STEP = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_STEP_MIN     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STEP_MAX     = 3'd4;

   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   localparam logic [GAIN_W-1:0] NOMINAL_STEP_RESET = 32'd134217728;
   localparam logic [GAIN_W-1:0] STEP_MIN_RESET     = 32'd16777216;
   localparam logic [GAIN_W-1:0] STEP_MAX_RESET     = 32'hFFFF_FFFF;

   localparam logic [SKIP_W-1:0] ADVANCE_MIN = 8'd1;
   localparam logic [SKIP_W-1:0] ADVANCE_MAX = 8'd255;

   typedef struct packed {
      logic signed [GAIN_W-1:0] step_gain;
      logic signed [GAIN_W-1:0] phase_gain;
      logic        [GAIN_W-1:0] nominal_step;
      logic        [GAIN_W-1:0] step_min;
      logic        [GAIN_W-1:0] step_max;
   } mmtr_cfg_type;

   // One item after the gain multipliers.
   typedef struct packed {
      logic                       valid;
      logic                       kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [PROD_W-1:0]   step_prod;
      logic signed [PROD_W-1:0]   phase_prod;
   } mmtr_prod_type;

endpackage

// ===== src/mmtr_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mueller-Muller timing recovery input channel
// Valid/ready channel carrying one sample or restart transaction.
// ----------------------------------------------------------------------------
interface mmtr_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [mmtr_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output kind, output sample, input ready);
   modport sink (input valid, input kind, input sample, output ready);
   modport monitor (input valid, input kind, input sample, input ready);
endinterface

// ===== src/mmtr_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mueller-Muller timing recovery result channel
// Valid/ready channel carrying one symbol decision transaction.
// ----------------------------------------------------------------------------
interface mmtr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mmtr_pkg::SAMPLE_W-1:0] decision;
   logic                                advance_clamped;

   modport source (output valid, output decision, output advance_clamped, input ready);
   modport sink (input valid, input decision, input advance_clamped, output ready);
   modport monitor (input valid, input decision, input advance_clamped, input ready);
endinterface

// ===== src/mmtr_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mueller-Muller timing recovery registers
// APB-style register file holding the loop gains, nominal step and step limits.
// ----------------------------------------------------------------------------
module mmtr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mmtr_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [mmtr_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [mmtr_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output mmtr_pkg::mmtr_cfg_type        cfg
);

   mmtr_pkg::mmtr_cfg_type               cfg_ff;
   logic [mmtr_pkg::REG_IDX_W-1:0]       reg_idx;
   logic                                 write_en;

   assign reg_idx    = csr_paddr[mmtr_pkg::ADDR_W-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_gain    <= '0;
         cfg_ff.phase_gain   <= '0;
         cfg_ff.nominal_step <= mmtr_pkg::NOMINAL_STEP_RESET;
         cfg_ff.step_min     <= mmtr_pkg::STEP_MIN_RESET;
         cfg_ff.step_max     <= mmtr_pkg::STEP_MAX_RESET;
      end else if (write_en) begin
         unique case (reg_idx)
            mmtr_pkg::REG_STEP_GAIN:    cfg_ff.step_gain    <= $signed(csr_pwdata);
            mmtr_pkg::REG_PHASE_GAIN:   cfg_ff.phase_gain   <= $signed(csr_pwdata);
            mmtr_pkg::REG_NOMINAL_STEP: cfg_ff.nominal_step <= csr_pwdata;
            mmtr_pkg::REG_STEP_MIN:     cfg_ff.step_min     <= csr_pwdata;
            mmtr_pkg::REG_STEP_MAX:     cfg_ff.step_max     <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         mmtr_pkg::REG_STEP_GAIN:    csr_prdata = cfg_ff.step_gain;
         mmtr_pkg::REG_PHASE_GAIN:   csr_prdata = cfg_ff.phase_gain;
         mmtr_pkg::REG_NOMINAL_STEP: csr_prdata = cfg_ff.nominal_step;
         mmtr_pkg::REG_STEP_MIN:     csr_prdata = cfg_ff.step_min;
         mmtr_pkg::REG_STEP_MAX:     csr_prdata = cfg_ff.step_max;
         default:                    csr_prdata = '0;
      endcase
   end

endmodule

// ===== src/mmtr_loop.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mueller-Muller timing recovery loop stage
// Skip counting, error forming, step and phase update, decision register.
// ----------------------------------------------------------------------------
module mmtr_loop (
   input  logic                    clock,
   input  logic                    reset,
   input  mmtr_pkg::mmtr_cfg_type  cfg,
   input  mmtr_pkg::mmtr_prod_type item,
   output logic                    item_take,
   mmtr_rsp_if.source              rsp_chan
);

   logic [mmtr_pkg::SKIP_W-1:0]            skip_ff, skip_in;
   logic [mmtr_pkg::GAIN_W-1:0]            step_ff, step_in;
   logic [mmtr_pkg::GAIN_W-1:0]            phase_ff, phase_in;
   logic signed [mmtr_pkg::SAMPLE_W-1:0]   prev_ff, prev_in;
   logic signed [mmtr_pkg::PROD_W-1:0]     prev_sprod_ff, prev_sprod_in;
   logic signed [mmtr_pkg::PROD_W-1:0]     prev_pprod_ff, prev_pprod_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [mmtr_pkg::SAMPLE_W-1:0]   rsp_decision_ff;
   logic                                   rsp_clamped_ff, rsp_clamped_in;

   logic                                   is_restart, is_decision, out_free;
   logic                                   prev_pos, prev_neg, cur_pos, cur_neg;
   logic signed [mmtr_pkg::TERM_W-1:0]     step_term_cur, step_term_prev;
   logic signed [mmtr_pkg::TERM_W-1:0]     phase_term_cur, phase_term_prev;
   logic signed [mmtr_pkg::ERR_W-1:0]      step_err, phase_err;
   logic signed [mmtr_pkg::STEP_W-1:0]     step_raw, step_lo, step_hi;
   logic [mmtr_pkg::GAIN_W-1:0]            step_clamped;
   logic signed [mmtr_pkg::PHASE_W-1:0]    phase_sum;
   logic signed [mmtr_pkg::INT_W-1:0]      advance;
   logic                                   adv_low, adv_high;
   logic [mmtr_pkg::SKIP_W-1:0]            skip_next;

   // Product times sign(v): the product itself, its negation or zero.
   function automatic logic signed [mmtr_pkg::TERM_W-1:0] signed_term(
      input logic                             pos,
      input logic                             neg,
      input logic signed [mmtr_pkg::PROD_W-1:0] prod
   );
      logic signed [mmtr_pkg::TERM_W-1:0] ext;
      ext = {prod[mmtr_pkg::PROD_W-1], prod};
      if (pos) begin
         signed_term = ext;
      end else if (neg) begin
         signed_term = -ext;
      end else begin
         signed_term = '0;
      end
   endfunction

   always_comb begin
      is_restart  = (item.kind == mmtr_pkg::KIND_RESTART);
      is_decision = !is_restart && (skip_ff == '0);
      out_free    = !rsp_valid_ff || rsp_chan.ready;
      item_take   = item.valid && (!is_decision || out_free);

      prev_neg = prev_ff[mmtr_pkg::SAMPLE_W-1];
      prev_pos = !prev_neg && (prev_ff != '0);
      cur_neg  = item.sample[mmtr_pkg::SAMPLE_W-1];
      cur_pos  = !cur_neg && (item.sample != '0);

      // The error times a gain is sign(prev)*cur*gain - sign(cur)*prev*gain, built from
      // products that were formed ahead of this stage.
      step_term_cur   = signed_term(prev_pos, prev_neg, item.step_prod);
      step_term_prev  = signed_term(cur_pos, cur_neg, prev_sprod_ff);
      phase_term_cur  = signed_term(prev_pos, prev_neg, item.phase_prod);
      phase_term_prev = signed_term(cur_pos, cur_neg, prev_pprod_ff);

      step_err  = {step_term_cur[mmtr_pkg::TERM_W-1], step_term_cur}
                - {step_term_prev[mmtr_pkg::TERM_W-1], step_term_prev};
      phase_err = {phase_term_cur[mmtr_pkg::TERM_W-1], phase_term_cur}
                - {phase_term_prev[mmtr_pkg::TERM_W-1], phase_term_prev};

      step_raw = $signed({{(mmtr_pkg::STEP_W-mmtr_pkg::GAIN_W){1'b0}}, step_ff})
               + $signed({{(mmtr_pkg::STEP_W-mmtr_pkg::ERR_W){step_err[mmtr_pkg::ERR_W-1]}},
                          step_err});
      step_lo  = $signed({{(mmtr_pkg::STEP_W-mmtr_pkg::GAIN_W){1'b0}}, cfg.step_min});
      step_hi  = $signed({{(mmtr_pkg::STEP_W-mmtr_pkg::GAIN_W){1'b0}}, cfg.step_max});

      // The lower bound wins when the bounds cross.
      priority if (step_lo > step_raw) begin
         step_clamped = cfg.step_min;
      end else if (step_hi < step_raw) begin
         step_clamped = cfg.step_max;
      end else begin
         step_clamped = step_raw[mmtr_pkg::GAIN_W-1:0];
      end

      phase_sum = $signed({{(mmtr_pkg::PHASE_W-mmtr_pkg::GAIN_W){1'b0}}, phase_ff})
                + $signed({{(mmtr_pkg::PHASE_W-mmtr_pkg::GAIN_W){1'b0}}, step_clamped})
                + $signed({{(mmtr_pkg::PHASE_W-mmtr_pkg::ERR_W){phase_err[mmtr_pkg::ERR_W-1]}},
                           phase_err});

      // An arithmetic shift of the phase gives the floor of its integer part.
      advance  = phase_sum[mmtr_pkg::PHASE_W-1:mmtr_pkg::FRAC_BITS];
      adv_low  = advance[mmtr_pkg::INT_W-1] || (advance == '0);
      adv_high = !advance[mmtr_pkg::INT_W-1]
              && (advance > $signed({{(mmtr_pkg::INT_W-mmtr_pkg::SKIP_W){1'b0}},
                                     mmtr_pkg::ADVANCE_MAX}));

      priority if (adv_low) begin
         skip_next = mmtr_pkg::ADVANCE_MIN - 1'b1;
      end else if (adv_high) begin
         skip_next = mmtr_pkg::ADVANCE_MAX - 1'b1;
      end else begin
         skip_next = advance[mmtr_pkg::SKIP_W-1:0] - 1'b1;
      end

      skip_in       = skip_ff;
      step_in       = step_ff;
      phase_in      = phase_ff;
      prev_in       = prev_ff;
      // With no decision the stored products are refreshed against the current gains.
      prev_sprod_in = prev_ff * cfg.step_gain;
      prev_pprod_in = prev_ff * cfg.phase_gain;

      if (item_take) begin
         if (is_restart) begin
            skip_in       = '0;
            step_in       = cfg.nominal_step;
            phase_in      = cfg.nominal_step;
            prev_in       = '0;
            prev_sprod_in = '0;
            prev_pprod_in = '0;
         end else if (is_decision) begin
            skip_in       = skip_next;
            step_in       = step_clamped;
            phase_in      = {{(mmtr_pkg::GAIN_W-mmtr_pkg::FRAC_BITS){1'b0}},
                             phase_sum[mmtr_pkg::FRAC_BITS-1:0]};
            prev_in       = item.sample;
            prev_sprod_in = item.step_prod;
            prev_pprod_in = item.phase_prod;
         end else begin
            skip_in       = skip_ff - 1'b1;
         end
      end

      rsp_valid_in   = (item_take && is_decision) || (rsp_valid_ff && !rsp_chan.ready);
      rsp_clamped_in = adv_low || adv_high;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff       <= '0;
         step_ff       <= mmtr_pkg::NOMINAL_STEP_RESET;
         phase_ff      <= mmtr_pkg::NOMINAL_STEP_RESET;
         prev_ff       <= '0;
         prev_sprod_ff <= '0;
         prev_pprod_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         skip_ff       <= skip_in;
         step_ff       <= step_in;
         phase_ff      <= phase_in;
         prev_ff       <= prev_in;
         prev_sprod_ff <= prev_sprod_in;
         prev_pprod_ff <= prev_pprod_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && is_decision) begin
         rsp_decision_ff <= item.sample;
         rsp_clamped_ff  <= rsp_clamped_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.decision        = rsp_decision_ff;
   assign rsp_chan.advance_clamped = rsp_clamped_ff;

endmodule

// ===== src/mueller_muller_timing_recovery_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mueller-Muller symbol timing recovery unit
// Picks symbol decision samples from a sample stream with a Mueller-Muller loop.
// ----------------------------------------------------------------------------
// The unit accepts one transaction per clock, sample or restart, and returns a
// decision transaction for each sample that lands on a symbol point. A sample
// passes from the input register into the gain product register, and the loop
// stage, which closes the step and phase update combinationally so that a
// decision may follow the previous one directly, loads the result register.
// Stalls on the result channel fill the pipeline registers before the input
// channel drops ready. There is no clearing pass after reset; registers are
// written through the APB port at byte address 4 times the register index.
module mueller_muller_timing_recovery_unit (
   input  logic                         clock,
   input  logic                         reset,
   mmtr_req_if.sink                     req_chan,
   mmtr_rsp_if.source                   rsp_chan,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [mmtr_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [mmtr_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [mmtr_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);

   mmtr_pkg::mmtr_cfg_type               cfg;
   logic                                 in_valid_ff, in_valid_in;
   logic                                 in_kind_ff;
   logic signed [mmtr_pkg::SAMPLE_W-1:0] in_sample_ff;
   mmtr_pkg::mmtr_prod_type              prod_ff, prod_in;
   logic                                 req_accept, prod_free, item_take;

   mmtr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   always_comb begin
      prod_free      = !prod_ff.valid || item_take;
      req_chan.ready = !in_valid_ff || prod_free;
      req_accept     = req_chan.valid && req_chan.ready;
      in_valid_in    = req_accept || (in_valid_ff && !prod_free);

      prod_in = prod_ff;
      if (prod_free) begin
         prod_in.valid      = in_valid_ff;
         prod_in.kind       = in_kind_ff;
         prod_in.sample     = in_sample_ff;
         prod_in.step_prod  = in_sample_ff * cfg.step_gain;
         prod_in.phase_prod = in_sample_ff * cfg.phase_gain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prod_ff.valid <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         prod_ff.valid <= prod_in.valid;
      end
      prod_ff.kind       <= prod_in.kind;
      prod_ff.sample     <= prod_in.sample;
      prod_ff.step_prod  <= prod_in.step_prod;
      prod_ff.phase_prod <= prod_in.phase_prod;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff   <= req_chan.kind;
         in_sample_ff <= req_chan.sample;
      end
   end

   mmtr_loop u_loop (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item      (prod_ff),
      .item_take (item_take),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== src/mmtr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mueller-Muller timing recovery checker
// Port-level checks on the channels of the timing recovery unit.
// ----------------------------------------------------------------------------
`include "mueller_muller_timing_recovery_unit_macros.svh"

module mmtr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [mmtr_pkg::SAMPLE_W-1:0] rsp_decision,
   input logic                                rsp_clamped
);

   // A stalled result transaction keeps its valid and its payload.
   `MMTR_ASSERT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `MMTR_ASSERT(a_dec_hold, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_decision))
   `MMTR_ASSERT(a_clamp_hold, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_clamped))

   // With the result register empty, nothing inside may hold back the input.
   `MMTR_ASSERT(a_ready_when_out_empty, clock, reset, !rsp_valid |-> req_ready)

   // Directly after reset no transaction can yet have got through the pipeline.
   `MMTR_ASSERT_ALWAYS(a_quiet_after_reset, clock, reset |=> !rsp_valid ##1 !rsp_valid)

endmodule

bind mueller_muller_timing_recovery_unit mmtr_checker u_mmtr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_decision (rsp_chan.decision),
   .rsp_clamped  (rsp_chan.advance_clamped)
);
